>>> src/frft_pkg.sv
// ----------------------------------------------------------------------------
// frft_pkg
// Shared codes, field widths and record types of the frame reassembly tracker.
// ----------------------------------------------------------------------------
package frft_pkg;

	localparam int StampW  = 32;
	localparam int CountW  = 16;
	localparam int PointsW = 10;
	localparam int ShortW  = 7;

	localparam logic [15:0] TIMEOUT_RESET = 16'd400;

	// input action codes
	localparam logic [1:0] ACT_FRAGMENT = 2'd0;
	localparam logic [1:0] ACT_TICK     = 2'd1;
	localparam logic [1:0] ACT_DISCARD  = 2'd2;
	localparam logic [1:0] ACT_NONE     = 2'd3;

	// classified command kinds
	localparam logic [1:0] CMD_FRAGMENT = 2'd0;
	localparam logic [1:0] CMD_TICK     = 2'd1;
	localparam logic [1:0] CMD_DISCARD  = 2'd2;
	localparam logic [1:0] CMD_REJECT   = 2'd3;

	// fragment verdicts
	localparam logic [1:0] VERDICT_ACCEPTED  = 2'd0;
	localparam logic [1:0] VERDICT_DUPLICATE = 2'd1;
	localparam logic [1:0] VERDICT_BAD_INDEX = 2'd2;
	localparam logic [1:0] VERDICT_BAD_TOTAL = 2'd3;

	localparam logic KIND_VERDICT = 1'b0;
	localparam logic KIND_PUBLISH = 1'b1;

	localparam logic CAUSE_COMPLETE   = 1'b0;
	localparam logic CAUSE_SUPERSEDED = 1'b1;

	typedef struct packed {
		logic [1:0]         kind;
		logic [1:0]         verdict;
		logic [StampW-1:0]  stamp;
		logic [CountW-1:0]  point_total;
		logic [PointsW-1:0] points;
	} cmd_t;

	typedef struct packed {
		logic              record_kind;
		logic [1:0]        verdict;
		logic              publish_cause;
		logic [StampW-1:0] out_stamp;
		logic [CountW-1:0] point_count;
		logic [ShortW-1:0] fragments_got;
		logic [ShortW-1:0] fragments_expected;
		logic              last;
	} rec_t;

endpackage

>>> src/frft_front.sv
// ----------------------------------------------------------------------------
// frft_front
// Decodes an input word and classifies it into a command for the back end.
// ----------------------------------------------------------------------------
module frft_front #(
	parameter int MAX_FRAGMENTS       = 64,
	parameter int MAX_FRAGMENT_POINTS = 1023,
	parameter int GW                  = 7,
	parameter int IW                  = 6
) (
	input  logic [1:0]          action,
	input  logic [95:0]         word,
	output logic                keep,
	output frft_pkg::cmd_t      cmd,
	output logic [GW-1:0]       ftot,
	output logic [IW-1:0]       idx
);
	import frft_pkg::*;

	logic [StampW-1:0]  stamp;
	logic [CountW-1:0]  frag_total;
	logic [CountW-1:0]  point_total;
	logic [CountW-1:0]  frag_index;
	logic [PointsW-1:0] points;

	assign stamp       = word[31:0];
	assign frag_total  = word[47:32];
	assign point_total = word[63:48];
	assign frag_index  = word[79:64];
	assign points      = word[89:80];

	assign keep = (action != ACT_NONE);
	assign ftot = frag_total[GW-1:0];
	assign idx  = frag_index[IW-1:0];

	always_comb begin
		cmd.stamp       = stamp;
		cmd.point_total = point_total;
		cmd.verdict     = VERDICT_ACCEPTED;
		cmd.kind        = CMD_FRAGMENT;
		if ({2'b00, points} > 12'(MAX_FRAGMENT_POINTS)) begin
			cmd.points = PointsW'(MAX_FRAGMENT_POINTS);
		end else begin
			cmd.points = points;
		end
		unique case (action)
			ACT_TICK:    cmd.kind = CMD_TICK;
			ACT_DISCARD: cmd.kind = CMD_DISCARD;
			default: begin
				priority if (frag_total > CountW'(MAX_FRAGMENTS)) begin
					cmd.kind    = CMD_REJECT;
					cmd.verdict = VERDICT_BAD_TOTAL;
				end else if (frag_index >= frag_total) begin
					cmd.kind    = CMD_REJECT;
					cmd.verdict = VERDICT_BAD_INDEX;
				end
			end
		endcase
	end

endmodule

>>> src/frft_queue.sv
// ----------------------------------------------------------------------------
// frft_queue
// Short first-in first-out queue of commands between front and back end.
// ----------------------------------------------------------------------------
module frft_queue #(
	parameter int Width = 8,
	parameter int Depth = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [Width-1:0] push_data,
	output logic             ready,
	input  logic             pop,
	output logic             valid,
	output logic [Width-1:0] pop_data
);
	localparam int PW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CW = $clog2(Depth + 1);

	logic [Width-1:0] mem_q [Depth];
	logic [PW-1:0]    wr_q;
	logic [PW-1:0]    rd_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push;
	logic             do_pop;

	assign ready    = (cnt_q != CW'(Depth));
	assign valid    = (cnt_q != '0);
	assign pop_data = mem_q[rd_q];
	assign do_push  = push && ready;
	assign do_pop   = pop && valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PW'(Depth - 1)) ? '0 : wr_q + PW'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(Depth - 1)) ? '0 : rd_q + PW'(1);
			end
			unique case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + CW'(1);
				2'b01:   cnt_q <= cnt_q - CW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

>>> src/frft_back.sv
// ----------------------------------------------------------------------------
// frft_back
// Open frame state, command execution and the buffer of result words.
// ----------------------------------------------------------------------------
module frft_back #(
	parameter int MAX_FRAGMENTS = 64,
	parameter int GW            = 7,
	parameter int IW            = 6
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [15:0]         timeout,
	input  logic                cmd_valid,
	input  frft_pkg::cmd_t      cmd,
	input  logic [GW-1:0]       ftot,
	input  logic [IW-1:0]       idx,
	output logic                cmd_pop,
	output logic                rec_valid,
	input  logic                rec_take,
	output frft_pkg::rec_t      rec
);
	import frft_pkg::*;

	logic                     open_q;
	logic [StampW-1:0]        stamp_q;
	logic [GW-1:0]            ftot_q;
	logic [CountW-1:0]        ptot_q;
	logic [GW-1:0]            got_q;
	logic [MAX_FRAGMENTS-1:0] map_q;
	logic [CountW-1:0]        sum_q;
	logic [15:0]              age_q;

	rec_t       rec_q [3];
	logic [1:0] cnt_q;

	logic                     take;
	logic                     fresh;
	logic                     sup_pub;
	logic [MAX_FRAGMENTS-1:0] base_map;
	logic [GW-1:0]            base_got;
	logic [CountW-1:0]        base_sum;
	logic                     dup;
	logic [GW-1:0]            new_got;
	logic [CountW:0]          sum_wide;
	logic [CountW-1:0]        new_sum;
	logic                     complete;
	logic [GW+6:0]            got_old_x;
	logic [GW+6:0]            ftot_old_x;
	logic [GW+6:0]            got_new_x;
	logic [GW+6:0]            ftot_new_x;
	rec_t                     sup_rec;
	rec_t                     ver_rec;
	rec_t                     comp_rec;
	rec_t                     load_rec [3];
	logic [1:0]               load_cnt;

	assign take      = rec_take && (cnt_q != 2'd0);
	assign rec_valid = (cnt_q != 2'd0);
	assign rec       = rec_q[0];
	assign cmd_pop   = cmd_valid && ((cnt_q == 2'd0) || ((cnt_q == 2'd1) && take));

	assign fresh = !open_q || (stamp_q != cmd.stamp) || (ftot_q != ftot) ||
		(ptot_q != cmd.point_total) || (age_q > timeout);
	assign sup_pub  = fresh && open_q && (got_q != '0);
	assign base_map = fresh ? '0 : map_q;
	assign base_got = fresh ? '0 : got_q;
	assign base_sum = fresh ? '0 : sum_q;
	assign dup      = base_map[idx];
	assign new_got  = dup ? base_got : base_got + GW'(1);
	assign sum_wide = {1'b0, base_sum} + (CountW + 1)'(cmd.points);
	assign new_sum  = dup ? base_sum :
		(sum_wide[CountW] ? {CountW{1'b1}} : sum_wide[CountW-1:0]);
	assign complete = (new_got == ftot);

	assign got_old_x  = {7'b0, got_q};
	assign ftot_old_x = {7'b0, ftot_q};
	assign got_new_x  = {7'b0, new_got};
	assign ftot_new_x = {7'b0, ftot};

	always_comb begin
		sup_rec.record_kind        = KIND_PUBLISH;
		sup_rec.verdict            = VERDICT_ACCEPTED;
		sup_rec.publish_cause      = CAUSE_SUPERSEDED;
		sup_rec.out_stamp          = stamp_q;
		sup_rec.point_count        = (sum_q > ptot_q) ? ptot_q : sum_q;
		sup_rec.fragments_got      = got_old_x[6:0];
		sup_rec.fragments_expected = ftot_old_x[6:0];
		sup_rec.last               = 1'b0;

		ver_rec.record_kind        = KIND_VERDICT;
		ver_rec.verdict            = (cmd.kind == CMD_REJECT) ? cmd.verdict :
			(dup ? VERDICT_DUPLICATE : VERDICT_ACCEPTED);
		ver_rec.publish_cause      = CAUSE_COMPLETE;
		ver_rec.out_stamp          = cmd.stamp;
		ver_rec.point_count        = '0;
		ver_rec.fragments_got      = '0;
		ver_rec.fragments_expected = '0;
		ver_rec.last               = 1'b0;

		comp_rec.record_kind        = KIND_PUBLISH;
		comp_rec.verdict            = VERDICT_ACCEPTED;
		comp_rec.publish_cause      = CAUSE_COMPLETE;
		comp_rec.out_stamp          = cmd.stamp;
		comp_rec.point_count        = (new_sum > cmd.point_total) ? cmd.point_total : new_sum;
		comp_rec.fragments_got      = got_new_x[6:0];
		comp_rec.fragments_expected = ftot_new_x[6:0];
		comp_rec.last               = 1'b1;

		load_rec[0] = ver_rec;
		load_rec[1] = comp_rec;
		load_rec[2] = comp_rec;
		load_cnt    = 2'd0;
		unique case (cmd.kind)
			CMD_REJECT: begin
				load_rec[0].last = 1'b1;
				load_cnt         = 2'd1;
			end
			CMD_FRAGMENT: begin
				load_cnt = 2'd1 + {1'b0, sup_pub} + {1'b0, complete};
				if (sup_pub) begin
					load_rec[0]      = sup_rec;
					load_rec[1]      = ver_rec;
					load_rec[1].last = !complete;
				end else begin
					load_rec[0].last = !complete;
				end
			end
			default: load_cnt = 2'd0;
		endcase
	end

	// result buffer, head drives the output
	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			rec_q[0] <= load_rec[0];
			rec_q[1] <= load_rec[1];
			rec_q[2] <= load_rec[2];
		end else if (take) begin
			rec_q[0] <= rec_q[1];
			rec_q[1] <= rec_q[2];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= 2'd0;
			open_q  <= 1'b0;
			stamp_q <= '0;
			ftot_q  <= '0;
			ptot_q  <= '0;
			got_q   <= '0;
			map_q   <= '0;
			sum_q   <= '0;
			age_q   <= '0;
		end else begin
			if (cmd_pop) begin
				cnt_q <= load_cnt;
			end else if (take) begin
				cnt_q <= cnt_q - 2'd1;
			end
			if (cmd_pop) begin
				unique case (cmd.kind)
					CMD_TICK: begin
						if (open_q && (age_q != 16'hFFFF)) begin
							age_q <= age_q + 16'd1;
						end
					end
					CMD_DISCARD: begin
						open_q <= 1'b0;
						got_q  <= '0;
						map_q  <= '0;
						sum_q  <= '0;
						age_q  <= '0;
					end
					CMD_FRAGMENT: begin
						stamp_q <= cmd.stamp;
						ftot_q  <= ftot;
						ptot_q  <= cmd.point_total;
						if (complete) begin
							open_q <= 1'b0;
							got_q  <= '0;
							map_q  <= '0;
							sum_q  <= '0;
							age_q  <= '0;
						end else begin
							open_q <= 1'b1;
							got_q  <= new_got;
							map_q  <= base_map | (MAX_FRAGMENTS'(1) << idx);
							sum_q  <= new_sum;
							if (fresh) begin
								age_q <= '0;
							end
						end
					end
					default: begin
						open_q <= open_q;
					end
				endcase
			end
		end
	end

endmodule

>>> src/fragment_frame_reassembly_tracker.sv
// ----------------------------------------------------------------------------
// fragment_frame_reassembly_tracker
// Tracks one open frame of fragment headers and reports verdicts and frames.
// ----------------------------------------------------------------------------
// Input words arrive on s_axis: tuser carries the action (fragment header,
// one millisecond tick, discard), tdata the fragment header fields. Result
// words leave on m_axis: tuser tells a fragment verdict from a published
// frame, tlast marks the final result caused by one input word. cfg writes
// the timeout in ticks and is always ready; write it only while idle.
// A front end classifies each input word and pushes all but no-action words
// into a two-entry command queue; the back end pops one command per cycle,
// while the result buffer is empty or its last word is being taken, into a
// three-word result buffer whose head is the registered output. A fragment
// yields one to three result words, one per cycle at the output while
// m_axis_tready is high; ticks and discards yield no result words.
// When m_axis stalls the result buffer holds, then the queue fills and
// s_axis_tready drops. Reset empties the queue and the buffer, closes the
// frame and sets the timeout to 400 ticks.
// ----------------------------------------------------------------------------
module fragment_frame_reassembly_tracker #(
	parameter int MAX_FRAGMENTS       = 64,
	parameter int MAX_FRAGMENT_POINTS = 1023
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// frame_stamp, fragment_total, frame_point_total, fragment_index,
	// fragment_points, zero pad
	input  logic [95:0] s_axis_tdata,
	// action
	input  logic [1:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// verdict, publish_cause, out_stamp, point_count, fragments_got,
	// fragments_expected, zero pad
	output logic [71:0] m_axis_tdata,
	// record_kind
	output logic        m_axis_tuser,
	output logic        m_axis_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);
	import frft_pkg::*;

	localparam int GW = $clog2(MAX_FRAGMENTS + 1);
	localparam int IW = (MAX_FRAGMENTS > 1) ? $clog2(MAX_FRAGMENTS) : 1;
	localparam int QW = $bits(cmd_t) + GW + IW;

	logic [15:0]   timeout_q;
	logic          keep;
	cmd_t          f_cmd;
	logic [GW-1:0] f_ftot;
	logic [IW-1:0] f_idx;
	logic          q_push;
	logic          q_ready;
	logic          q_valid;
	logic          q_pop;
	logic [QW-1:0] q_data;
	cmd_t          b_cmd;
	logic [GW-1:0] b_ftot;
	logic [IW-1:0] b_idx;
	rec_t          rec;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			timeout_q <= cfg_data;
		end
	end

	frft_front #(
		.MAX_FRAGMENTS       (MAX_FRAGMENTS),
		.MAX_FRAGMENT_POINTS (MAX_FRAGMENT_POINTS),
		.GW                  (GW),
		.IW                  (IW)
	) u_front (
		.action (s_axis_tuser),
		.word   (s_axis_tdata),
		.keep   (keep),
		.cmd    (f_cmd),
		.ftot   (f_ftot),
		.idx    (f_idx)
	);

	assign s_axis_tready = q_ready;
	assign q_push        = s_axis_tvalid && keep;

	frft_queue #(
		.Width (QW),
		.Depth (2)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data ({f_idx, f_ftot, f_cmd}),
		.ready     (q_ready),
		.pop       (q_pop),
		.valid     (q_valid),
		.pop_data  (q_data)
	);

	assign {b_idx, b_ftot, b_cmd} = q_data;

	frft_back #(
		.MAX_FRAGMENTS (MAX_FRAGMENTS),
		.GW            (GW),
		.IW            (IW)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.timeout   (timeout_q),
		.cmd_valid (q_valid),
		.cmd       (b_cmd),
		.ftot      (b_ftot),
		.idx       (b_idx),
		.cmd_pop   (q_pop),
		.rec_valid (m_axis_tvalid),
		.rec_take  (m_axis_tready),
		.rec       (rec)
	);

	assign m_axis_tuser = rec.record_kind;
	assign m_axis_tlast = rec.last;
	assign m_axis_tdata = {7'b0, rec.fragments_expected, rec.fragments_got,
		rec.point_count, rec.out_stamp, rec.publish_cause, rec.verdict};

endmodule
